### rtl/core/rpcf_pkg.sv
// Shared constants, types and codes of the raster peak clip filter.
package rpcf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned PIXEL_BITS = 16;

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned WID_W      = COL_W + 1;
  localparam int unsigned HGT_W      = ROW_W + 1;
  localparam int unsigned CFG_DATA_W = (WID_W > HGT_W) ? WID_W : HGT_W;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [WID_W-1:0]      wid_t;
  typedef logic [HGT_W-1:0]      hgt_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Line buffer access request for one cycle.
  typedef struct packed {
    logic rd_en;
    col_t rd_col;
    logic cen_we;
    col_t cen_col;
    pix_t cen_data;
    logic up_we;
    col_t up_col;
    pix_t up_data;
  } lb_req_t;

  // Neighbour layout of a pixel in the filter stage.
  typedef struct packed {
    logic has_up;
    logic has_left;
    logic has_right;
    logic has_down;
    logic row_end;
    logic frame_end;
    col_t col;
  } emit_ctl_t;

endpackage

### rtl/core/rpcf_if.sv
// Stream interfaces of the raster peak clip filter: pixel words in, result words out.
interface rpcf_in_if;
  logic          valid;
  logic          ready;
  logic          operation;
  rpcf_pkg::pix_t pixel_value;

  modport source (output valid, output operation, output pixel_value, input ready);
  modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

interface rpcf_out_if;
  logic           valid;
  logic           ready;
  rpcf_pkg::pix_t out_value;
  logic           row_end;
  logic           frame_end;

  modport source (output valid, output out_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_value, input row_end, input frame_end,
                  output ready);
endinterface

### rtl/core/rpcf_line_buf.sv
// Line buffers: original centre row (one write, two reads) and filtered upper row.
module rpcf_line_buf (
  input  logic              clk_i,
  input  rpcf_pkg::lb_req_t req_i,
  output rpcf_pkg::pix_t    cur_o,
  output rpcf_pkg::pix_t    right_o,
  output rpcf_pkg::pix_t    up_o
);
  import rpcf_pkg::*;

  pix_t cen_mem [MAX_WIDTH];
  pix_t up_mem  [MAX_WIDTH];
  pix_t cur_q, right_q, up_q;
  col_t right_col;

  assign right_col = req_i.rd_col + col_t'(1);

  // Read-before-write: a read of the column being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      cur_q   <= cen_mem[req_i.rd_col];
      right_q <= cen_mem[right_col];
      up_q    <= up_mem[req_i.rd_col];
    end
    if (req_i.cen_we) begin
      cen_mem[req_i.cen_col] <= req_i.cen_data;
    end
    if (req_i.up_we) begin
      up_mem[req_i.up_col] <= req_i.up_data;
    end
  end

  assign cur_o   = cur_q;
  assign right_o = right_q;
  assign up_o    = up_q;

endmodule

### rtl/core/raster_peak_clip_filter.sv
// Raster peak clip filter top level: counters, filter stage and output register.
// A result word passes the filter stage register and the output register before it is valid.
// Throughput: one word per cycle unless the output stalls; two centre columns are read at once.
// Output runs one row behind the input; drain words flush the last row.
// Reset: width 1024, height 1, counters and valid flags cleared; line buffers not cleared.
module raster_peak_clip_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [rpcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rpcf_in_if.sink                         pix_in,
  rpcf_out_if.source                      res_out
);
  import rpcf_pkg::*;

  // Frame geometry
  wid_t width_q;
  hgt_t height_q;

  // Input and output positions
  col_t in_col_q, in_col_d;
  row_t in_row_q, in_row_d;
  col_t out_col_q, out_col_d;
  row_t out_row_q, out_row_d;
  logic done_q, done_d;

  // Filter stage
  logic      b_valid_q;
  emit_ctl_t b_ctl_q, a_ctl;
  pix_t      b_down_q;
  pix_t      left_q;

  // Output register
  logic out_valid_q;
  pix_t out_value_q;
  logic out_row_end_q, out_frame_end_q;

  logic    accept, a_emit, a_write, b_adv;
  lb_req_t lb_req;
  pix_t    cur_rd, right_rd, up_rd;
  pix_t    up_v, best, val;
  logic    any_nb, all_less;
  wid_t    out_col_inc, in_col_inc;
  hgt_t    out_row_inc, in_row_inc;
  wid_t    cfg_w;
  hgt_t    cfg_h;

  // Hold the filter stage while the output word waits; take a new word otherwise.
  assign b_adv        = b_valid_q && (!out_valid_q || res_out.ready);
  assign pix_in.ready = !b_valid_q || b_adv;
  assign accept       = pix_in.valid && pix_in.ready;

  assign out_col_inc = {1'b0, out_col_q} + wid_t'(1);
  assign out_row_inc = {1'b0, out_row_q} + hgt_t'(1);
  assign in_col_inc  = {1'b0, in_col_q} + wid_t'(1);
  assign in_row_inc  = {1'b0, in_row_q} + hgt_t'(1);

  // Decode the incoming word and advance the positions.
  always_comb begin
    a_emit    = 1'b0;
    a_write   = 1'b0;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    done_d    = done_q;

    a_ctl.has_up    = (out_row_q != '0);
    a_ctl.has_left  = (out_col_q != '0);
    a_ctl.has_right = (out_col_inc < width_q);
    a_ctl.has_down  = (pix_in.operation == OP_PIXEL);
    a_ctl.row_end   = (out_col_inc == width_q);
    a_ctl.frame_end = a_ctl.row_end && (out_row_inc == height_q);
    a_ctl.col       = out_col_q;

    if (accept) begin
      if (pix_in.operation == OP_PIXEL) begin
        // Pixels after the last row has arrived are dropped.
        if (!done_q) begin
          a_write = 1'b1;
          a_emit  = (in_row_q != '0);
          if (in_col_inc >= width_q) begin
            in_col_d = '0;
            if (in_row_inc >= height_q) begin
              done_d = 1'b1;
            end else begin
              in_row_d = in_row_q + row_t'(1);
            end
          end else begin
            in_col_d = in_col_q + col_t'(1);
          end
        end
      end else begin
        a_emit = done_q;
      end

      if (a_emit) begin
        if (a_ctl.row_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + row_t'(1);
        end else begin
          out_col_d = out_col_q + col_t'(1);
        end
        // Last pixel of the frame: start over.
        if (pix_in.operation == OP_DRAIN && a_ctl.frame_end) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          done_d    = 1'b0;
        end
      end
    end
  end

  // Filter: clip a strict local maximum to its largest neighbour.
  always_comb begin
    // In a one-column frame the pixel above is the previous result.
    up_v     = (width_q == wid_t'(1)) ? left_q : up_rd;
    best     = '0;
    all_less = 1'b1;
    any_nb   = b_ctl_q.has_up | b_ctl_q.has_left | b_ctl_q.has_right | b_ctl_q.has_down;
    if (b_ctl_q.has_up) begin
      if (cur_rd > up_v) begin
        if (up_v > best) best = up_v;
      end else begin
        all_less = 1'b0;
      end
    end
    if (b_ctl_q.has_left) begin
      if (cur_rd > left_q) begin
        if (left_q > best) best = left_q;
      end else begin
        all_less = 1'b0;
      end
    end
    if (b_ctl_q.has_right) begin
      if (cur_rd > right_rd) begin
        if (right_rd > best) best = right_rd;
      end else begin
        all_less = 1'b0;
      end
    end
    if (b_ctl_q.has_down) begin
      if (cur_rd > b_down_q) begin
        if (b_down_q > best) best = b_down_q;
      end else begin
        all_less = 1'b0;
      end
    end
    val = (any_nb && all_less) ? best : cur_rd;
  end

  always_comb begin
    lb_req.rd_en    = a_emit;
    lb_req.rd_col   = out_col_q;
    lb_req.cen_we   = a_write;
    lb_req.cen_col  = in_col_q;
    lb_req.cen_data = pix_in.pixel_value;
    lb_req.up_we    = b_adv;
    lb_req.up_col   = b_ctl_q.col;
    lb_req.up_data  = val;
  end

  rpcf_line_buf u_line_buf (
    .clk_i   (clk_i),
    .req_i   (lb_req),
    .cur_o   (cur_rd),
    .right_o (right_rd),
    .up_o    (up_rd)
  );

  // Clamp register writes to the supported frame size.
  always_comb begin
    cfg_w = cfg_data_i[WID_W-1:0];
    if (cfg_w == '0) cfg_w = wid_t'(1);
    if (cfg_w > wid_t'(MAX_WIDTH)) cfg_w = wid_t'(MAX_WIDTH);
    cfg_h = cfg_data_i[HGT_W-1:0];
    if (cfg_h == '0) cfg_h = hgt_t'(1);
    if (cfg_h > hgt_t'(MAX_HEIGHT)) cfg_h = hgt_t'(MAX_HEIGHT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= wid_t'(MAX_WIDTH);
      height_q    <= hgt_t'(1);
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      done_q      <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else if (cfg_we_i) begin
      // A register write aborts the frame.
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  width_q  <= cfg_w;
        CFG_FRAME_HEIGHT: height_q <= cfg_h;
        default:          width_q  <= width_q;
      endcase
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      done_q      <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      done_q    <= done_d;
      if (pix_in.ready) begin
        b_valid_q <= a_emit;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
        left_q      <= val;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (a_emit) begin
      b_ctl_q  <= a_ctl;
      b_down_q <= pix_in.pixel_value;
    end
    if (b_adv) begin
      out_value_q     <= val;
      out_row_end_q   <= b_ctl_q.row_end;
      out_frame_end_q <= b_ctl_q.frame_end;
    end
  end

  assign res_out.valid     = out_valid_q;
  assign res_out.out_value = out_value_q;
  assign res_out.row_end   = out_row_end_q;
  assign res_out.frame_end = out_frame_end_q;

endmodule

### tb/raster_peak_clip_filter_checker.sv
// Checker of the raster peak clip filter: tracks the frame, predicts result words, compares.
`timescale 1ns / 100ps

module raster_peak_clip_filter_checker
  import rpcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rpcf_in_if                    pix_mon,
  rpcf_out_if                   res_mon,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  typedef struct packed {
    pix_t value;
    logic row_end;
    logic frame_end;
  } clip_word_t;

  clip_word_t  clipped_q[$];
  wid_t        frame_w;
  hgt_t        frame_h;
  pix_t        up_line   [MAX_WIDTH];   // filtered row above the output row
  pix_t        orig_line [MAX_WIDTH];   // original pixels, one row deep
  pix_t        left_pix;
  col_t        in_col;
  row_t        in_row;
  col_t        out_col;
  row_t        out_row;
  logic        rows_in_done;
  int unsigned fails;

  function automatic void restart_frame();
    left_pix     = '0;
    in_col       = '0;
    in_row       = '0;
    out_col      = '0;
    out_row      = '0;
    rows_in_done = 1'b0;
  endfunction

  // Clamp the written size into range; any write aborts the frame.
  function automatic void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    wid_t w_req;
    hgt_t h_req;
    w_req = data[WID_W-1:0];
    h_req = data[HGT_W-1:0];
    if (idx == CFG_FRAME_WIDTH) begin
      frame_w = (w_req == 0) ? wid_t'(1) : (w_req > MAX_WIDTH) ? wid_t'(MAX_WIDTH) : w_req;
    end else begin
      frame_h = (h_req == 0) ? hgt_t'(1) : (h_req > MAX_HEIGHT) ? hgt_t'(MAX_HEIGHT) : h_req;
    end
    restart_frame();
  endfunction

  // Clip the pixel at the output position, queue its word and advance.
  function automatic logic clip_emit(logic has_down, pix_t down_pix);
    pix_t       cur;
    pix_t       best;
    pix_t       nb_val [4];
    logic       nb_has [4];
    logic       any_nb;
    logic       all_less;
    clip_word_t word;
    int         k;
    cur       = orig_line[out_col];
    nb_has[0] = (out_row != 0);
    nb_val[0] = up_line[out_col];
    nb_has[1] = (out_col != 0);
    nb_val[1] = left_pix;
    nb_has[2] = (out_col + 1 < frame_w);
    nb_val[2] = nb_has[2] ? orig_line[col_t'(out_col + 1)] : '0;
    nb_has[3] = has_down;
    nb_val[3] = down_pix;
    best      = '0;
    any_nb    = 1'b0;
    all_less  = 1'b1;
    for (k = 0; k < 4; k++) begin
      if (nb_has[k]) begin
        any_nb = 1'b1;
        if (cur > nb_val[k]) begin
          if (nb_val[k] > best) best = nb_val[k];
        end else begin
          all_less = 1'b0;
        end
      end
    end
    word.value     = (any_nb && all_less) ? best : cur;
    word.row_end   = (out_col + 1 == frame_w);
    word.frame_end = word.row_end && (out_row + 1 == frame_h);
    up_line[out_col] = word.value;
    left_pix         = word.value;
    clipped_q.push_back(word);
    if (word.row_end) begin
      out_col = '0;
      out_row = row_t'(out_row + 1);
    end else begin
      out_col = col_t'(out_col + 1);
    end
    return word.frame_end;
  endfunction

  function automatic void take_word(op_e op, pix_t pix);
    if (op == OP_PIXEL) begin
      if (!rows_in_done) begin
        if (in_row != 0) void'(clip_emit(1'b1, pix));
        orig_line[in_col] = pix;
        if (in_col + 1 >= frame_w) begin
          in_col = '0;
          if (in_row + 1 >= frame_h) rows_in_done = 1'b1;
          else in_row = row_t'(in_row + 1);
        end else begin
          in_col = col_t'(in_col + 1);
        end
      end
    end else if (rows_in_done) begin
      if (clip_emit(1'b0, '0)) restart_frame();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    clip_word_t want;
    if (!rst_ni) begin
      frame_w = wid_t'(MAX_WIDTH);
      frame_h = hgt_t'(1);
      restart_frame();
      clipped_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) set_register(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (res_mon.valid && res_mon.ready) begin
        if (clipped_q.size() == 0) begin
          fails++;
          $error("result word with none expected: out_value %h", res_mon.out_value);
        end else begin
          want = clipped_q.pop_front();
          if (res_mon.out_value !== want.value) begin
            fails++;
            $error("out_value: expected %h, actual %h", want.value, res_mon.out_value);
          end
          if (res_mon.row_end !== want.row_end) begin
            fails++;
            $error("row_end: expected %b, actual %b", want.row_end, res_mon.row_end);
          end
          if (res_mon.frame_end !== want.frame_end) begin
            fails++;
            $error("frame_end: expected %b, actual %b", want.frame_end, res_mon.frame_end);
          end
        end
      end
      if (pix_mon.valid && pix_mon.ready) begin
        take_word(op_e'(pix_mon.operation), pix_mon.pixel_value);
      end
    end
    pending_o    <= clipped_q.size();
    fail_count_o <= fails;
  end

endmodule

### tb/raster_peak_clip_filter_tb.sv
// Testbench top of the raster peak clip filter: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module raster_peak_clip_filter_tb;
  import rpcf_pkg::*;

  // Cycles to let pass after the last expected word before touching a register;
  // a result word passes the filter stage and the output register after its accept.
  localparam int unsigned LAT_CYCLES      = 4;
  // Long receiver hold-off, long enough to fill the block and stall its input.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the hold-off plus a random stall segment.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned RANDOM_WORDS    = 560;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic                  cfg_idx  = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned clipped_pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;
  int unsigned frame_words  = 0;
  logic        hold_off_req = 1'b0;

  rpcf_in_if  pix_in ();
  rpcf_out_if res_out ();

  raster_peak_clip_filter u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_in    (pix_in),
    .res_out   (res_out)
  );

  raster_peak_clip_filter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pix_mon     (pix_in),
    .res_mon     (res_out),
    .pending_o   (clipped_pending),
    .fail_count_o(fail_count)
  );

  always #5 clk_i = ~clk_i;

  // Count cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stall in segments of changing character; on request, hold off
  // for a long stretch so that the sender keeps offering into a full block.
  initial begin : receiver
    int unsigned seg_left;
    int unsigned seg_mode;
    int unsigned phase_cnt;
    logic        rdy;
    seg_left  = 0;
    seg_mode  = 0;
    phase_cnt = 0;
    res_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 80);
      end
      seg_left--;
      phase_cnt++;
      case (seg_mode)
        0:       rdy = 1'b1;                            // no stalls at all
        1:       rdy = ($urandom_range(0, 1) == 1);     // coin toss
        2:       rdy = ($urandom_range(0, 4) == 0);     // mostly stalled
        default: rdy = (phase_cnt % 4 != 0);            // regular one-in-four gap
      endcase
      res_out.ready <= rdy;
    end
  end

  // Offer one word and hold it until accepted. The sender runs in bursts;
  // between bursts drop valid for a random gap (sometimes none).
  task automatic push_word(op_e op, pix_t pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_in.valid       <= 1'b1;
    pix_in.operation   <= op;
    pix_in.pixel_value <= pix;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  // Drop valid and wait until every expected word has arrived, then give the
  // block time to finish anything that makes no word.
  task automatic settle();
    pix_in.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (clipped_pending != 0) @(posedge clk_i);
    repeat (LAT_CYCLES) @(posedge clk_i);
  endtask

  // Write both size registers on consecutive edges; only call while idle.
  task automatic write_frame_regs(int unsigned w_code, int unsigned h_code);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w_code);
    @(posedge clk_i);
    cfg_idx  <= CFG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h_code);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Pixel content styles: full range, tiny range for ties, top of range,
  // flat background with occasional spikes.
  function automatic pix_t pick_pixel(int unsigned mode);
    case (mode)
      0:       return pix_t'($urandom_range(0, 65535));
      1:       return pix_t'($urandom_range(0, 3));
      2:       return pix_t'($urandom_range(65532, 65535));
      default: return ($urandom_range(0, 7) == 0) ? pix_t'($urandom_range(0, 65535))
                                                  : pix_t'($urandom_range(100, 103));
    endcase
  endfunction

  // Send n_pix pixels and n_drain drains of one frame, with the odd stray word
  // the block has to ignore: a drain while the frame is still arriving, a
  // pixel while the last row drains.
  task automatic send_frame(int unsigned n_pix, int unsigned n_drain);
    int unsigned mode;
    int unsigned k;
    mode = $urandom_range(0, 3);
    for (k = 0; k < n_pix; k++) begin
      if ($urandom_range(0, 24) == 0) push_word(OP_DRAIN, pick_pixel(0));
      push_word(OP_PIXEL, pick_pixel(mode));
    end
    for (k = 0; k < n_drain; k++) begin
      if ($urandom_range(0, 24) == 0) push_word(OP_PIXEL, pick_pixel(0));
      push_word(OP_DRAIN, pick_pixel(0));
    end
    frame_words += n_pix + n_drain;
  endtask

  // One setting of the registers: some whole frames, then optionally a frame
  // cut short, which the next register write aborts. With odd_regs the sizes
  // are written out of range or with stray upper bits that the block drops.
  task automatic clip_phase(int unsigned w, int unsigned h, int unsigned frames,
                            bit odd_regs, bit cut_short);
    int unsigned w_code;
    int unsigned h_code;
    int unsigned n_pix;
    w_code = w;
    h_code = h;
    if (odd_regs) begin
      if (w == MAX_WIDTH) w_code = $urandom_range(MAX_WIDTH + 1, 2047);
      else if (w == 1) w_code = 0;
      w_code = w_code | ($urandom_range(1, 3) << WID_W);
      if (h == MAX_HEIGHT) h_code = $urandom_range(MAX_HEIGHT + 1, 8191);
      else if (h == 1) h_code = 0;
    end
    write_frame_regs(w_code, h_code);
    repeat (frames) begin
      send_frame(w * h, w);
      // a drain after the frame has ended finds nothing to flush
      if ($urandom_range(0, 7) == 0) push_word(OP_DRAIN, pick_pixel(0));
    end
    if (cut_short) begin
      n_pix = $urandom_range(1, w * h);
      send_frame(n_pix, (n_pix == w * h) ? $urandom_range(0, w - 1) : 0);
    end
    settle();
  endtask

  initial begin : stimulus
    pix_in.valid       <= 1'b0;
    pix_in.operation   <= OP_PIXEL;
    pix_in.pixel_value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-pixel frame from zero-valued registers: it has no neighbours,
    // so it passes unchanged. Drain early, then feed a pixel the block
    // must ignore once the frame is complete.
    write_frame_regs(0, 0);
    push_word(OP_DRAIN, 16'hFFFF);
    push_word(OP_PIXEL, 16'hFFFF);
    push_word(OP_PIXEL, 16'h1234);
    push_word(OP_DRAIN, 16'h0000);
    push_word(OP_PIXEL, 16'h0000);
    push_word(OP_DRAIN, 16'h5A5A);
    settle();

    // 2x2 with a full-scale peak in the corner, then a stray drain.
    write_frame_regs(2, 2);
    push_word(OP_PIXEL, 16'hFFFF);
    push_word(OP_PIXEL, 16'h0001);
    push_word(OP_PIXEL, 16'h0002);
    push_word(OP_PIXEL, 16'h0000);
    push_word(OP_DRAIN, 16'h0000);
    push_word(OP_DRAIN, 16'hFFFF);
    push_word(OP_DRAIN, 16'h0000);
    settle();

    // Single row with a peak in the middle: only left and right count.
    write_frame_regs(3, 1);
    push_word(OP_PIXEL, 16'h0005);
    push_word(OP_PIXEL, 16'hFFFF);
    push_word(OP_PIXEL, 16'h0007);
    push_word(OP_DRAIN, 16'h0000);
    push_word(OP_DRAIN, 16'h0000);
    push_word(OP_DRAIN, 16'h0000);
    settle();

    // Back-pressure: hold the receiver off while a frame streams in.
    hold_off_req = 1'b1;
    clip_phase(16, 4, 1, 1'b0, 1'b0);

    // Random sizes, mostly small.
    frame_words = 0;
    while (frame_words < RANDOM_WORDS) begin : random_phase
      int unsigned w;
      int unsigned h;
      case ($urandom_range(0, 7))
        0:       begin w = $urandom_range(1, 3);   h = $urandom_range(1, 3);  end
        1:       begin w = $urandom_range(13, 64); h = $urandom_range(1, 3);  end
        2:       begin w = $urandom_range(1, 2);   h = $urandom_range(4, 24); end
        default: begin w = $urandom_range(2, 12);  h = $urandom_range(2, 6);  end
      endcase
      if ($urandom_range(0, 9) == 0) hold_off_req = 1'b1;
      clip_phase(w, h, $urandom_range(1, 3), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 3) == 0);
    end

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
